/* rtl/tcw_pkg.sv */
// Package for the text console writer: command codes, character constants,
// field widths and the command and status records between controller and datapath.
// It has no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned COL_W = 7;
  localparam int unsigned ROW_W = 6;
  localparam int unsigned CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [COL_W:0] TAB_STOP = 8'd8;
  localparam logic [COL_W:0] TAB_MASK = ~(TAB_STOP - 8'd1);
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

  typedef enum logic [1:0] {
    FUNC_PUT = 2'd0,
    FUNC_SET_CURSOR = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ = 2'd3
  } func_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fill_we;
    logic fill_reset_attr;
    logic rd_load;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  scroll;
    logic  fill_last;
  } dp_status_t;

endpackage

/* rtl/text_console_writer.sv */
// Top level of the text console writer: joins the controller and the datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Channel   | Transaction taken when       | Signals
// ----------+------------------------------+-------------------------------------------------
// command   | start_i high and busy_o low  | func_i, char_code_i, col_x_i, row_y_i
// result    | done_o high (one cycle)      | cursor_col_o, cursor_row_o, cell_char_o,
//           |                              | cell_attr_o, scrolled_o
// attribute | text_attribute_we_i high     | text_attribute_i
//
// A read passes through the registered store read port before its result is loaded. A scroll
// blanks one row through the single write port; a clear screen fills every cell. After reset
// busy_o stays high while the store is blanked.
// The result is flagged by done_o for one cycle only; the receiver cannot stall it.
`timescale 1ns / 1ps

module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::COORD_W-1:0]  col_x_i,
  input  logic [tcw_pkg::COORD_W-1:0]  row_y_i,
  input  logic                         text_attribute_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   text_attribute_i,
  output logic                         done_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]   cell_attr_o,
  output logic                         scrolled_o
);
  import tcw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .col_x_i      (col_x_i),
    .row_y_i      (row_y_i),
    .attr_we_i    (text_attribute_we_i),
    .attr_i       (text_attribute_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_char_o  (cell_char_o),
    .cell_attr_o  (cell_attr_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

/* rtl/tcw_ctrl.sv */
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the command and status records.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tcw_pkg::dp_status_t status_i,
  output tcw_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import tcw_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_FILL = 5'b01000,
    ST_READ = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill_we = 1'b1;
        cmd_o.fill_reset_attr = 1'b1;
        if (status_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.func == FUNC_CLEAR || status_i.scroll) begin
          state_d = ST_FILL;
        end else if (status_i.func == FUNC_READ) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
          done_d = 1'b1;
        end
      end
      ST_FILL: begin
        cmd_o.fill_we = 1'b1;
        if (status_i.fill_last) begin
          state_d = ST_IDLE;
          done_d = 1'b1;
        end
      end
      ST_READ: begin
        cmd_o.rd_load = 1'b1;
        state_d = ST_IDLE;
        done_d = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

/* rtl/tcw_datapath.sv */
// Datapath of the text console writer: screen store, cursor, scroll offset and result registers.
// Depends on tcw_pkg; sequenced by tcw_ctrl through the command record.
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcw_pkg::ctrl_cmd_t                cmd_i,
  output tcw_pkg::dp_status_t               status_o,
  input  logic [1:0]                        func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code_i,
  input  logic [tcw_pkg::COORD_W-1:0]       col_x_i,
  input  logic [tcw_pkg::COORD_W-1:0]       row_y_i,
  input  logic                              attr_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]        attr_i,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row_o,
  output logic [tcw_pkg::CHAR_W-1:0]        cell_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]        cell_attr_o,
  output logic                              scrolled_o
);
  import tcw_pkg::*;

  localparam int unsigned DEPTH = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_COL = ADDR_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(ROWS);

  logic [CELL_W-1:0] mem_q [DEPTH];

  func_e              func_q;
  logic [CHAR_W-1:0]  char_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ROW_W-1:0]   top_q, top_d;
  logic [ATTR_W-1:0]  attr_q;
  logic [ADDR_W-1:0]  fill_addr_q, fill_left_q;
  logic [CELL_W-1:0]  rd_data_q;
  logic               rd_ok_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic [ATTR_W-1:0]  out_attr_q;
  logic               out_scroll_q;

  logic               scroll;
  logic               put_write;
  logic               rd_ok;
  logic [COL_W:0]     col_inc, col_tab;
  logic [ADDR_W-1:0]  cur_addr, rd_addr, mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_we;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                 input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= ROW_LIMIT) begin
      sum = sum - ROW_LIMIT;
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(int'(prow) * COLUMNS) + ADDR_W'(col);
  endfunction

  assign col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
  assign col_tab = ({1'b0, col_q} + TAB_STOP) & TAB_MASK;
  assign rd_ok = (x_q < COORD_W'(COLUMNS)) && (y_q < COORD_W'(ROWS));
  assign cur_addr = cell_addr(phys_row(row_q, top_q), col_q);
  assign rd_addr = cell_addr(phys_row(y_q[ROW_W-1:0], top_q), x_q[COL_W-1:0]);

  always_comb begin
    logic new_line;
    new_line = 1'b0;
    col_d = col_q;
    row_d = row_q;
    top_d = top_q;
    scroll = 1'b0;
    put_write = 1'b0;
    case (func_q)
      FUNC_PUT: begin
        if (char_q == CH_NEWLINE) begin
          new_line = 1'b1;
        end else if (char_q == CH_RETURN) begin
          col_d = '0;
        end else if (char_q == CH_TAB) begin
          if (col_tab >= COL_LIMIT) begin
            new_line = 1'b1;
          end else begin
            col_d = col_tab[COL_W-1:0];
          end
        end else begin
          put_write = 1'b1;
          if (col_inc >= COL_LIMIT) begin
            new_line = 1'b1;
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
        if (new_line) begin
          col_d = '0;
          if (row_q == LAST_ROW) begin
            scroll = 1'b1;
            top_d = (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
      end
      FUNC_SET_CURSOR: begin
        if (rd_ok) begin
          col_d = x_q[COL_W-1:0];
          row_d = y_q[ROW_W-1:0];
        end
      end
      FUNC_CLEAR: begin
        col_d = '0;
        row_d = '0;
        top_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = fill_addr_q;
    mem_wdata = {(cmd_i.fill_reset_attr ? RESET_ATTR : attr_q), CH_SPACE};
    if (cmd_i.fill_we) begin
      mem_we = 1'b1;
    end else if (cmd_i.exec && put_write) begin
      mem_we = 1'b1;
      mem_waddr = cur_addr;
      mem_wdata = {attr_q, char_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      char_q <= char_code_i;
      x_q <= col_x_i;
      y_q <= row_y_i;
    end
    if (cmd_i.exec) begin
      rd_ok_q <= rd_ok;
      out_char_q <= '0;
      out_attr_q <= '0;
      out_scroll_q <= scroll;
    end else if (cmd_i.rd_load && rd_ok_q) begin
      out_char_q <= rd_data_q[CHAR_W-1:0];
      out_attr_q <= rd_data_q[CELL_W-1:CHAR_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      top_q <= '0;
      attr_q <= RESET_ATTR;
      fill_addr_q <= '0;
      fill_left_q <= LAST_CELL;
    end else begin
      if (attr_we_i) begin
        attr_q <= attr_i;
      end
      if (cmd_i.exec) begin
        col_q <= col_d;
        row_q <= row_d;
        top_q <= top_d;
        if (func_q == FUNC_CLEAR) begin
          fill_addr_q <= '0;
          fill_left_q <= LAST_CELL;
        end else if (scroll) begin
          fill_addr_q <= cell_addr(top_q, '0);
          fill_left_q <= LAST_COL;
        end
      end else if (cmd_i.fill_we) begin
        fill_addr_q <= fill_addr_q + ADDR_W'(1);
        fill_left_q <= fill_left_q - ADDR_W'(1);
      end
    end
  end

  assign status_o.func = func_q;
  assign status_o.scroll = scroll;
  assign status_o.fill_last = (fill_left_q == '0);

  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign cell_char_o = out_char_q;
  assign cell_attr_o = out_attr_q;
  assign scrolled_o = out_scroll_q;

endmodule

/* tb/text_console_writer_tb.sv */
// Self-checking testbench for text_console_writer: a queue-fed command driver, a result
// monitor and a behavioural model of the 80x25 screen store, cursor and text attribute.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS = 25;
  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned TAB_WIDTH = 8;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 122;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    func_e               func;
    logic [CHAR_W-1:0]   char_code;
    logic [COORD_W-1:0]  col_x;
    logic [COORD_W-1:0]  row_y;
  } command_t;

  typedef struct packed {
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic               scrolled;
  } console_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [COORD_W-1:0] col_x_i = '0;
  logic [COORD_W-1:0] row_y_i = '0;
  logic text_attribute_we_i = 1'b0;
  logic [ATTR_W-1:0] text_attribute_i = '0;
  logic done_o;
  logic [COL_W-1:0] cursor_col_o;
  logic [ROW_W-1:0] cursor_row_o;
  logic [CHAR_W-1:0] cell_char_o;
  logic [ATTR_W-1:0] cell_attr_o;
  logic scrolled_o;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .func_i(func_i),
    .char_code_i(char_code_i),
    .col_x_i(col_x_i),
    .row_y_i(row_y_i),
    .text_attribute_we_i(text_attribute_we_i),
    .text_attribute_i(text_attribute_i),
    .done_o(done_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .cell_char_o(cell_char_o),
    .cell_attr_o(cell_attr_o),
    .scrolled_o(scrolled_o)
  );

  always #5 clk_i = ~clk_i;

  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned model_col = 0;
  int unsigned model_row = 0;
  logic [ATTR_W-1:0] model_attr = RESET_ATTR;

  command_t pending_commands [$];
  console_result_t expected_results [$];
  command_t driven_cmd = '0;
  logic offering = 1'b0;
  logic hold_for_drain = 1'b0;
  int unsigned gap_left = 0;
  int unsigned gap_max = MAX_GAP;
  int unsigned failure_count = 0;

  function automatic logic advance_line();
    logic [CELL_W-1:0] blank;
    blank = {model_attr, CH_SPACE};
    model_col = 0;
    model_row++;
    if (model_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = blank;
      model_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t apply_command(command_t cmd);
    console_result_t res;
    logic [CELL_W-1:0] read_word;
    res = '0;
    case (cmd.func)
      FUNC_PUT: begin
        if (cmd.char_code == CH_NEWLINE) begin
          res.scrolled = advance_line();
        end else if (cmd.char_code == CH_RETURN) begin
          model_col = 0;
        end else if (cmd.char_code == CH_TAB) begin
          model_col = (model_col / TAB_WIDTH + 1) * TAB_WIDTH;
          if (model_col >= COLUMNS) res.scrolled = advance_line();
        end else begin
          screen_model[model_row * COLUMNS + model_col] = {model_attr, cmd.char_code};
          model_col++;
          if (model_col >= COLUMNS) res.scrolled = advance_line();
        end
      end
      FUNC_SET_CURSOR: begin
        if (cmd.col_x < COLUMNS && cmd.row_y < ROWS) begin
          model_col = 32'(cmd.col_x);
          model_row = 32'(cmd.row_y);
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {model_attr, CH_SPACE};
        model_col = 0;
        model_row = 0;
      end
      default: begin
        if (cmd.col_x < COLUMNS && cmd.row_y < ROWS) begin
          read_word = screen_model[cmd.row_y * COLUMNS + cmd.col_x];
          res.cell_char = read_word[CHAR_W-1:0];
          res.cell_attr = read_word[CELL_W-1:CHAR_W];
        end
      end
    endcase
    res.cursor_col = model_col[COL_W-1:0];
    res.cursor_row = model_row[ROW_W-1:0];
    return res;
  endfunction

  task automatic report_failure(string what);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  task automatic queue_command(func_e f, logic [CHAR_W-1:0] ch, logic [COORD_W-1:0] x,
                               logic [COORD_W-1:0] y);
    pending_commands.push_back(command_t'{f, ch, x, y});
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_commands.size() != 0 || offering || expected_results.size() != 0 ||
           busy_o !== 1'b0);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    text_attribute_we_i <= 1'b1;
    text_attribute_i <= value;
    @(posedge clk_i);
    text_attribute_we_i <= 1'b0;
    model_attr = value;
  endtask

  // A command transaction completes at an edge with start high and busy low; the next one is offered
  // after a random gap and, when hold_for_drain is drawn, only once every outstanding result has come back.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_results.push_back(apply_command(driven_cmd));
      gap_left = $urandom_range(0, gap_max);
      hold_for_drain = (gap_max != 0) && ($urandom_range(0, 39) == 0);
      offering = 1'b0;
    end
    if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (!(hold_for_drain && expected_results.size() != 0) &&
                   pending_commands.size() != 0) begin
        driven_cmd = pending_commands.pop_front();
        offering = 1'b1;
      end
    end
    start_i <= offering;
    func_i <= driven_cmd.func;
    char_code_i <= driven_cmd.char_code;
    col_x_i <= driven_cmd.col_x;
    row_y_i <= driven_cmd.row_y;
  end

  always @(posedge clk_i) begin
    console_result_t got;
    console_result_t want;
    if (rst_ni && done_o) begin
      got = {cursor_col_o, cursor_row_o, cell_char_o, cell_attr_o, scrolled_o};
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result transaction with none expected: %p", got));
      end else begin
        want = expected_results.pop_front();
        if (got.cursor_col !== want.cursor_col)
          report_failure($sformatf("cursor_col expected %0d, got %0d",
                                   want.cursor_col, got.cursor_col));
        if (got.cursor_row !== want.cursor_row)
          report_failure($sformatf("cursor_row expected %0d, got %0d",
                                   want.cursor_row, got.cursor_row));
        if (got.cell_char !== want.cell_char)
          report_failure($sformatf("cell_char expected 0x%02h, got 0x%02h",
                                   want.cell_char, got.cell_char));
        if (got.cell_attr !== want.cell_attr)
          report_failure($sformatf("cell_attr expected 0x%02h, got 0x%02h",
                                   want.cell_attr, got.cell_attr));
        if (got.scrolled !== want.scrolled)
          report_failure($sformatf("scrolled expected %0b, got %0b",
                                   want.scrolled, got.scrolled));
      end
    end
  end

  initial begin
    command_t cmd;
    int unsigned sel;
    for (int i = 0; i < CELLS; i++) screen_model[i] = {RESET_ATTR, CH_SPACE};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Directed sequence under the reset attribute.
    queue_command(FUNC_READ, 8'h00, 8'd0, 8'd0);
    queue_command(FUNC_READ, 8'hFF, 8'd79, 8'd24);
    queue_command(FUNC_READ, 8'h00, 8'd80, 8'd0);
    queue_command(FUNC_READ, 8'h00, 8'd0, 8'd25);
    queue_command(FUNC_READ, 8'h00, 8'd255, 8'd255);
    queue_command(FUNC_PUT, 8'h41, 8'd0, 8'd0);
    queue_command(FUNC_PUT, 8'h00, 8'd255, 8'd255);
    queue_command(FUNC_PUT, 8'hFF, 8'd0, 8'd0);
    queue_command(FUNC_PUT, CH_TAB, 8'd0, 8'd0);
    queue_command(FUNC_PUT, 8'h42, 8'd0, 8'd0);
    queue_command(FUNC_PUT, CH_RETURN, 8'd0, 8'd0);
    queue_command(FUNC_PUT, CH_NEWLINE, 8'd0, 8'd0);
    queue_command(FUNC_SET_CURSOR, 8'h00, 8'd76, 8'd3);
    queue_command(FUNC_PUT, CH_TAB, 8'd0, 8'd0);
    queue_command(FUNC_SET_CURSOR, 8'h00, 8'd80, 8'd0);
    queue_command(FUNC_SET_CURSOR, 8'h00, 8'd0, 8'd25);
    queue_command(FUNC_SET_CURSOR, 8'h00, 8'd255, 8'd255);
    queue_command(FUNC_SET_CURSOR, 8'h00, 8'd79, 8'd24);
    queue_command(FUNC_PUT, 8'h5A, 8'd0, 8'd0);
    queue_command(FUNC_READ, 8'h00, 8'd79, 8'd23);
    queue_command(FUNC_PUT, CH_NEWLINE, 8'd0, 8'd0);
    queue_command(FUNC_SET_CURSOR, 8'h00, 8'd75, 8'd24);
    queue_command(FUNC_PUT, CH_TAB, 8'd0, 8'd0);
    queue_command(FUNC_READ, 8'h00, 8'd0, 8'd1);
    queue_command(FUNC_CLEAR, 8'h00, 8'd0, 8'd0);
    queue_command(FUNC_READ, 8'h00, 8'd0, 8'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_attribute(p == 0 ? 8'h00 : p == 1 ? 8'hFF : ATTR_W'($urandom_range(0, 255)));
      gap_max = (p % 3 == 2) ? 0 : MAX_GAP;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        cmd.char_code = CHAR_W'($urandom_range(0, 255));
        cmd.col_x = COORD_W'($urandom_range(0, 255));
        cmd.row_y = COORD_W'($urandom_range(0, 255));
        if (sel < 60) begin
          cmd.func = FUNC_PUT;
          case ($urandom_range(0, 19))
            0: cmd.char_code = CH_NEWLINE;
            1: cmd.char_code = CH_RETURN;
            2: cmd.char_code = CH_TAB;
            default: ;
          endcase
        end else if (sel < 72) begin
          cmd.func = FUNC_SET_CURSOR;
          if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 1) != 0) begin
              cmd.col_x = COORD_W'($urandom_range(COLUMNS - TAB_WIDTH, COLUMNS - 1));
              cmd.row_y = COORD_W'($urandom_range(ROWS - 3, ROWS - 1));
            end else begin
              cmd.col_x = COORD_W'($urandom_range(0, COLUMNS - 1));
              cmd.row_y = COORD_W'($urandom_range(0, ROWS - 1));
            end
          end
        end else if (sel < 73) begin
          cmd.func = FUNC_CLEAR;
        end else begin
          cmd.func = FUNC_READ;
          if ($urandom_range(0, 6) != 0) begin
            cmd.col_x = COORD_W'($urandom_range(0, COLUMNS - 1));
            cmd.row_y = COORD_W'($urandom_range(0, ROWS - 1));
          end
        end
        pending_commands.push_back(cmd);
      end
    end

    wait_idle();
    repeat (2 * COLUMNS) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
